// ===== rtl/rls_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package rls_pkg;

  localparam logic [2:0] CMD_CLEAR   = 3'd0;
  localparam logic [2:0] CMD_APPEND  = 3'd1;
  localparam logic [2:0] CMD_NEW     = 3'd2;
  localparam logic [2:0] CMD_HYP     = 3'd3;
  localparam logic [2:0] CMD_EXTRACT = 3'd4;
  localparam logic [2:0] CMD_NONE    = 3'd5;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_REJECT = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  localparam logic [1:0] REG_FIT_DIST = 2'd0;
  localparam logic [1:0] REG_EXT_DIST = 2'd1;
  localparam logic [1:0] REG_MAX_HYP  = 2'd2;

  localparam logic [7:0] FIT_DIST_RST = 8'd5;
  localparam logic [7:0] EXT_DIST_RST = 8'd10;
  localparam logic [7:0] MAX_HYP_RST  = 8'd99;

  typedef struct packed {
    logic [7:0] fit_dist;
    logic [7:0] ext_dist;
    logic [7:0] max_hyp;
  } cfg_t;

endpackage
`default_nettype wire

// ===== rtl/rls_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rls_ram #(
  parameter int WIDTH = 23,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rls_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rls_front #(
  parameter int COORD_BITS = 11,
  parameter int IDX_W      = 12,
  parameter int IN_W       = 48
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_W-1:0]       in_tdata,
  input  wire logic [2:0]            in_tuser,
  output logic                       q_valid,
  input  wire logic                  q_pop,
  output logic      [2:0]            q_cmd,
  output logic      [COORD_BITS-1:0] q_x,
  output logic      [COORD_BITS-1:0] q_y,
  output logic      [IDX_W-1:0]      q_ia,
  output logic      [IDX_W-1:0]      q_ib
);

  localparam int PAY_W = 2 * COORD_BITS + 2 * IDX_W;

  logic [2:0]       ent_cmd_r [2];
  logic [PAY_W-1:0] ent_pay_r [2];
  logic             wr_ptr_r;
  logic             rd_ptr_r;
  logic [1:0]       fill_r;
  logic [2:0]       kind;
  logic             push;
  logic             pop;

  // fold the unused command codes into one do-nothing kind
  always_comb begin
    case (in_tuser)
      rls_pkg::CMD_CLEAR, rls_pkg::CMD_APPEND, rls_pkg::CMD_NEW,
      rls_pkg::CMD_HYP, rls_pkg::CMD_EXTRACT: kind = in_tuser;
      default: kind = rls_pkg::CMD_NONE;
    endcase
  end

  assign in_tready = (fill_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (fill_r != 2'd0);
  assign pop       = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (push) begin
        ent_cmd_r[wr_ptr_r] <= kind;
        ent_pay_r[wr_ptr_r] <= in_tdata[PAY_W-1:0];
        wr_ptr_r            <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        fill_r <= fill_r + 2'd1;
      end else if (pop && !push) begin
        fill_r <= fill_r - 2'd1;
      end
    end
  end

  assign q_cmd = ent_cmd_r[rd_ptr_r];
  assign q_x   = ent_pay_r[rd_ptr_r][COORD_BITS-1:0];
  assign q_y   = ent_pay_r[rd_ptr_r][2*COORD_BITS-1:COORD_BITS];
  assign q_ia  = ent_pay_r[rd_ptr_r][2*COORD_BITS+IDX_W-1:2*COORD_BITS];
  assign q_ib  = ent_pay_r[rd_ptr_r][PAY_W-1:2*COORD_BITS+IDX_W];

endmodule
`default_nettype wire

// ===== rtl/rls_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rls_back #(
  parameter int MAX_POINTS     = 4096,
  parameter int COORD_BITS     = 11,
  parameter int EXTRACT_WINDOW = 64,
  parameter int IDX_W          = 12,
  parameter int CNT_W          = 13,
  parameter int OUT_W          = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire rls_pkg::cfg_t         cfg,
  input  wire logic                  q_valid,
  output logic                       q_pop,
  input  wire logic [2:0]            q_cmd,
  input  wire logic [COORD_BITS-1:0] q_x,
  input  wire logic [COORD_BITS-1:0] q_y,
  input  wire logic [IDX_W-1:0]      q_ia,
  input  wire logic [IDX_W-1:0]      q_ib,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic      [OUT_W-1:0]      out_tdata,
  output logic                       out_tuser,
  output logic                       out_tlast
);

  localparam int C     = COORD_BITS;
  localparam int D_W   = C + 1;
  localparam int P_W   = 2 * D_W;
  localparam int CR_W  = P_W + 1;
  localparam int AW    = (CR_W > 32) ? 32 : CR_W;
  localparam int SQ_W  = 2 * AW;
  localparam int LEN_W = 2 * C + 1;
  localparam int RHS_W = LEN_W + 16;
  localparam int CMP_W = (SQ_W > RHS_W) ? SQ_W : RHS_W;
  localparam int M_W   = 2 * C + 1;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RDA  = 4'd1;
  localparam logic [3:0] S_RDB  = 4'd2;
  localparam logic [3:0] S_LEN  = 4'd3;
  localparam logic [3:0] S_RHS  = 4'd4;
  localparam logic [3:0] S_SCAN = 4'd5;
  localparam logic [3:0] S_FIN  = 4'd6;
  localparam logic [3:0] S_EMIT = 4'd7;

  logic [3:0] state_r;

  // search state
  logic [CNT_W-1:0] total_r, target_r, best_inl_r, cnt_r;
  logic [1:0]       rem_r;
  logic [7:0]       hyp_used_r;
  logic             best_valid_r;
  logic [C-1:0]     best_x1_r, best_y1_r, best_x2_r, best_y2_r;

  // current line
  logic                    mode_hyp_r;
  logic [IDX_W-1:0]        ib_r;
  logic [C-1:0]            a_x_r, a_y_r;
  logic                    a_rm_r;
  logic [C-1:0]            x1_r, y1_r, x2_r, y2_r;
  logic signed [D_W-1:0]   dx_r, dy_r;
  logic [LEN_W-1:0]        len2_r;
  logic [15:0]             dsq_r;
  logic [RHS_W-1:0]        rhs_r;
  logic [CNT_W-1:0]        scan_addr_r, scan_end_r;

  // scan pipeline
  logic                    v0_r, v1_r, v2_r, v3_r;
  logic [IDX_W-1:0]        i0_r, i1_r, i2_r, i3_r;
  logic [M_W-1:0]          m1_r, m2_r, m3_r;
  logic signed [P_W-1:0]   p1_r, p2_r;
  logic [CR_W-1:0]         abs_r;
  logic [SQ_W-1:0]         sq_r;
  logic                    ovf3_r;

  // held extracted point and result fields
  logic                    pend_v_r;
  logic [C-1:0]            pend_x_r, pend_y_r;
  logic [IDX_W-1:0]        pend_i_r;
  logic [1:0]              res_st_r;
  logic [CNT_W-1:0]        res_hc_r;
  logic                    res_imp_r, res_found_r;
  logic [C-1:0]            res_x_r, res_y_r;
  logic [IDX_W-1:0]        res_i_r;

  logic                    out_v_r, out_found_r, out_last_r, out_imp_r, out_done_r;
  logic [1:0]              out_st_r;
  logic [CNT_W-1:0]        out_hc_r, out_best_r;
  logic [C-1:0]            out_x_r, out_y_r;
  logic [IDX_W-1:0]        out_i_r;

  logic                    ram_we, ram_re;
  logic [IDX_W-1:0]        ram_waddr, ram_raddr;
  logic [M_W-1:0]          ram_wdata, ram_q;

  logic                    out_free, out_load, done, issue, hit, adv, pipe_empty;
  logic [C-1:0]            rq_x, rq_y;
  logic                    rq_rm;
  logic signed [D_W-1:0]   ex, ey;
  logic signed [P_W-1:0]   p1_nxt, p2_nxt;
  logic signed [CR_W-1:0]  cr;
  logic [CR_W-1:0]         abs_nxt;
  logic [AW-1:0]           a_lo;
  logic [SQ_W-1:0]         sq_nxt;
  logic signed [P_W-1:0]   sqx, sqy;
  logic [7:0]              dsel;
  logic [CNT_W:0]          win_end;
  logic [2:0]              rem_sum;
  logic                    ia_bad, ib_bad;

  rls_ram #(.WIDTH(M_W), .DEPTH(MAX_POINTS)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  assign rq_x  = ram_q[C-1:0];
  assign rq_y  = ram_q[2*C-1:C];
  assign rq_rm = ram_q[2*C];

  assign out_free = !out_v_r || out_tready;
  assign done     = (best_inl_r >= target_r) || (hyp_used_r >= cfg.max_hyp);
  assign issue    = (state_r == S_SCAN) && (scan_addr_r < scan_end_r);
  assign ia_bad   = ({1'b0, q_ia} >= total_r);
  assign ib_bad   = ({1'b0, q_ib} >= total_r);
  assign q_pop    = (state_r == S_IDLE) && q_valid;

  // datapath of the point test
  always_comb begin
    ex      = $signed({1'b0, rq_x}) - $signed({1'b0, x1_r});
    ey      = $signed({1'b0, rq_y}) - $signed({1'b0, y1_r});
    p1_nxt  = dx_r * ey;
    p2_nxt  = dy_r * ex;
    cr      = $signed({p1_r[P_W-1], p1_r}) - $signed({p2_r[P_W-1], p2_r});
    abs_nxt = cr[CR_W-1] ? CR_W'(-cr) : CR_W'(cr);
    a_lo    = abs_r[AW-1:0];
    sq_nxt  = SQ_W'(a_lo) * SQ_W'(a_lo);
    hit     = v3_r && !m3_r[2*C] && !ovf3_r && (CMP_W'(sq_r) < CMP_W'(rhs_r));
    sqx     = dx_r * dx_r;
    sqy     = dy_r * dy_r;
    dsel    = mode_hyp_r ? cfg.fit_dist : cfg.ext_dist;
    win_end = (CNT_W+1)'(q_ia) + (CNT_W+1)'(EXTRACT_WINDOW);
    rem_sum = {1'b0, rem_r} + 3'd2;
  end

  // stall the scan while a second extracted point finds the output still full
  assign adv = !((state_r == S_SCAN) && !mode_hyp_r && hit && pend_v_r && !out_free);
  assign pipe_empty = !issue && !v0_r && !v1_r && !v2_r && !v3_r;

  // the output register takes a new result this cycle
  assign out_load = ((state_r == S_EMIT) && out_free) ||
                    ((state_r == S_SCAN) && adv && hit && !mode_hyp_r && pend_v_r);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = total_r[IDX_W-1:0];
    ram_wdata = {1'b0, q_y, q_x};
    ram_re    = 1'b0;
    ram_raddr = scan_addr_r[IDX_W-1:0];
    case (state_r)
      S_IDLE: begin
        if (q_valid && q_cmd == rls_pkg::CMD_APPEND &&
            total_r != CNT_W'(MAX_POINTS)) begin
          ram_we = 1'b1;
        end
        if (q_valid && q_cmd == rls_pkg::CMD_HYP) begin
          ram_re    = 1'b1;
          ram_raddr = q_ia;
        end
      end
      S_RDA: begin
        ram_re    = 1'b1;
        ram_raddr = ib_r;
      end
      S_SCAN: begin
        ram_re = issue && adv;
        if (adv && hit && !mode_hyp_r) begin
          ram_we    = 1'b1;
          ram_waddr = i3_r;
          ram_wdata = {1'b1, m3_r[2*C-1:0]};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      total_r      <= '0;
      target_r     <= '0;
      rem_r        <= 2'd0;
      best_inl_r   <= '0;
      best_valid_r <= 1'b0;
      hyp_used_r   <= 8'd0;
      best_x1_r    <= '0;
      best_y1_r    <= '0;
      best_x2_r    <= '0;
      best_y2_r    <= '0;
      v0_r         <= 1'b0;
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      v3_r         <= 1'b0;
      pend_v_r     <= 1'b0;
      out_v_r      <= 1'b0;
    end else begin
      if (out_v_r && out_tready && !out_load) begin
        out_v_r <= 1'b0;
      end
      if (adv) begin
        v0_r   <= issue;
        i0_r   <= scan_addr_r[IDX_W-1:0];
        v1_r   <= v0_r;
        i1_r   <= i0_r;
        m1_r   <= ram_q;
        p1_r   <= p1_nxt;
        p2_r   <= p2_nxt;
        v2_r   <= v1_r;
        i2_r   <= i1_r;
        m2_r   <= m1_r;
        abs_r  <= abs_nxt;
        v3_r   <= v2_r;
        i3_r   <= i2_r;
        m3_r   <= m2_r;
        sq_r   <= sq_nxt;
        ovf3_r <= (abs_r >> AW) != '0;
      end
      case (state_r)
        S_IDLE: begin
          res_hc_r    <= '0;
          res_imp_r   <= 1'b0;
          res_found_r <= 1'b0;
          res_x_r     <= '0;
          res_y_r     <= '0;
          res_i_r     <= '0;
          if (q_valid) begin
            case (q_cmd)
              rls_pkg::CMD_CLEAR, rls_pkg::CMD_NEW: begin
                res_st_r <= rls_pkg::ST_OK;
                state_r  <= S_EMIT;
                if (q_cmd == rls_pkg::CMD_CLEAR) begin
                  total_r  <= '0;
                  target_r <= '0;
                  rem_r    <= 2'd0;
                end
                best_inl_r   <= '0;
                best_valid_r <= 1'b0;
                hyp_used_r   <= 8'd0;
                best_x1_r    <= '0;
                best_y1_r    <= '0;
                best_x2_r    <= '0;
                best_y2_r    <= '0;
              end
              rls_pkg::CMD_APPEND: begin
                state_r <= S_EMIT;
                if (total_r == CNT_W'(MAX_POINTS)) begin
                  res_st_r <= rls_pkg::ST_FULL;
                end else begin
                  res_st_r <= rls_pkg::ST_OK;
                  total_r  <= total_r + 1'b1;
                  // track floor(2*total/3) with a running residue
                  if (rem_sum >= 3'd3) begin
                    target_r <= target_r + 1'b1;
                    rem_r    <= 2'(rem_sum - 3'd3);
                  end else begin
                    rem_r <= rem_sum[1:0];
                  end
                end
              end
              rls_pkg::CMD_HYP: begin
                if (done || ia_bad || ib_bad) begin
                  res_st_r <= rls_pkg::ST_REJECT;
                  state_r  <= S_EMIT;
                end else begin
                  res_st_r   <= rls_pkg::ST_OK;
                  ib_r       <= q_ib;
                  mode_hyp_r <= 1'b1;
                  state_r    <= S_RDA;
                end
              end
              rls_pkg::CMD_EXTRACT: begin
                if (ia_bad) begin
                  res_st_r <= rls_pkg::ST_REJECT;
                  state_r  <= S_EMIT;
                end else if (best_valid_r) begin
                  res_st_r    <= rls_pkg::ST_OK;
                  mode_hyp_r  <= 1'b0;
                  x1_r        <= best_x1_r;
                  y1_r        <= best_y1_r;
                  dx_r        <= $signed({1'b0, best_x2_r}) - $signed({1'b0, best_x1_r});
                  dy_r        <= $signed({1'b0, best_y2_r}) - $signed({1'b0, best_y1_r});
                  scan_addr_r <= CNT_W'(q_ia);
                  scan_end_r  <= (win_end > (CNT_W+1)'(total_r)) ? total_r
                                                                  : win_end[CNT_W-1:0];
                  state_r     <= S_LEN;
                end else begin
                  res_st_r <= rls_pkg::ST_OK;
                  state_r  <= S_EMIT;
                end
              end
              default: begin
                res_st_r <= rls_pkg::ST_OK;
                state_r  <= S_EMIT;
              end
            endcase
          end
        end
        S_RDA: begin
          a_x_r   <= rq_x;
          a_y_r   <= rq_y;
          a_rm_r  <= rq_rm;
          state_r <= S_RDB;
        end
        S_RDB: begin
          if (a_rm_r || rq_rm || a_x_r == rq_x) begin
            res_st_r <= rls_pkg::ST_REJECT;
            state_r  <= S_EMIT;
          end else begin
            x1_r        <= a_x_r;
            y1_r        <= a_y_r;
            x2_r        <= rq_x;
            y2_r        <= rq_y;
            dx_r        <= $signed({1'b0, rq_x}) - $signed({1'b0, a_x_r});
            dy_r        <= $signed({1'b0, rq_y}) - $signed({1'b0, a_y_r});
            scan_addr_r <= '0;
            scan_end_r  <= total_r;
            cnt_r       <= '0;
            state_r     <= S_LEN;
          end
        end
        S_LEN: begin
          len2_r  <= LEN_W'(sqx + sqy);
          dsq_r   <= 16'(dsel) * 16'(dsel);
          state_r <= S_RHS;
        end
        S_RHS: begin
          rhs_r   <= RHS_W'(dsq_r) * RHS_W'(len2_r);
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          if (adv) begin
            if (issue) begin
              scan_addr_r <= scan_addr_r + 1'b1;
            end
            if (hit) begin
              if (mode_hyp_r) begin
                cnt_r <= cnt_r + 1'b1;
              end else begin
                // hand the older point on, keep the newest one back for tlast
                if (pend_v_r) begin
                  out_v_r     <= 1'b1;
                  out_st_r    <= rls_pkg::ST_OK;
                  out_hc_r    <= '0;
                  out_best_r  <= best_inl_r;
                  out_imp_r   <= 1'b0;
                  out_done_r  <= done;
                  out_found_r <= 1'b1;
                  out_x_r     <= pend_x_r;
                  out_y_r     <= pend_y_r;
                  out_i_r     <= pend_i_r;
                  out_last_r  <= 1'b0;
                end
                pend_v_r <= 1'b1;
                pend_x_r <= m3_r[C-1:0];
                pend_y_r <= m3_r[2*C-1:C];
                pend_i_r <= i3_r;
              end
            end
            if (pipe_empty) begin
              state_r <= S_FIN;
            end
          end
        end
        S_FIN: begin
          state_r <= S_EMIT;
          if (mode_hyp_r) begin
            res_hc_r <= cnt_r;
            if (hyp_used_r != 8'hFF) begin
              hyp_used_r <= hyp_used_r + 8'd1;
            end
            if (cnt_r > best_inl_r) begin
              best_inl_r   <= cnt_r;
              best_valid_r <= 1'b1;
              best_x1_r    <= x1_r;
              best_y1_r    <= y1_r;
              best_x2_r    <= x2_r;
              best_y2_r    <= y2_r;
              res_imp_r    <= 1'b1;
            end
          end else if (pend_v_r) begin
            pend_v_r    <= 1'b0;
            res_found_r <= 1'b1;
            res_x_r     <= pend_x_r;
            res_y_r     <= pend_y_r;
            res_i_r     <= pend_i_r;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_v_r     <= 1'b1;
            out_st_r    <= res_st_r;
            out_hc_r    <= res_hc_r;
            out_best_r  <= best_inl_r;
            out_imp_r   <= res_imp_r;
            out_done_r  <= done;
            out_found_r <= res_found_r;
            out_x_r     <= res_x_r;
            out_y_r     <= res_y_r;
            out_i_r     <= res_i_r;
            out_last_r  <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_found_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = OUT_W'({out_i_r, out_y_r, out_x_r, out_done_r, out_imp_r,
                              out_best_r, out_hc_r, out_st_r});

  a_pipe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_SCAN) |-> !(v0_r || v1_r || v2_r || v3_r))
    else $error("scan pipeline busy outside a scan");
  a_total_cap: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= CNT_W'(MAX_POINTS))
    else $error("point total above store depth");
  a_pend_extract: assert property (@(posedge clk) disable iff (!rst_n)
    pend_v_r |-> ((state_r == S_SCAN || state_r == S_FIN) && !mode_hyp_r))
    else $error("held point outside an extract");
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r != 2'd3)
    else $error("target residue out of range");

endmodule
`default_nettype wire

// ===== rtl/ransac_line_search_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel   Dir  Handshake            Payload
// in_*      in   in_tvalid/in_tready  tuser: command; tdata: points and indices
// out_*     out  out_tvalid/out_tready tuser: point_found; tlast: last; tdata: result
// cfg_*     in   cfg_we               cfg_index, cfg_wdata (no read-back)
//
// A request is registered in the queue before the back end takes it.
// Clear, append, new search and unknown commands go from idle to the emit state and back.
// A hypothesis fetches both samples and sets up the line, scans stored point after stored
// point through the single read port of the point store, drains the test pipeline, and
// finishes and loads the result.
// An extract scans at most EXTRACT_WINDOW stored points and waits while the output stalls.
// Reset is synchronous and clears only control state; the point store has no
// clearing pass. A two-entry request queue lets input run ahead of the scan.
module ransac_line_search_unit #(
  parameter int MAX_POINTS     = 4096,
  parameter int COORD_BITS     = 11,
  parameter int EXTRACT_WINDOW = 64
) (
  input  wire logic clk,
  input  wire logic rst_n,
  // tdata: coord_x, coord_y, index_a, index_b (from bit 0 up), zero padded
  // tuser: command
  input  wire logic in_tvalid,
  output logic      in_tready,
  input  wire logic [((2*COORD_BITS+2*$clog2(MAX_POINTS)+7)/8)*8-1:0] in_tdata,
  input  wire logic [2:0] in_tuser,
  // tdata: status, hypothesis_count, best_count, improved, search_done,
  //        point_x, point_y, point_index (from bit 0 up), zero padded
  // tuser: point_found
  output logic      out_tvalid,
  input  wire logic out_tready,
  output logic [((2*COORD_BITS+3*$clog2(MAX_POINTS)+6+7)/8)*8-1:0] out_tdata,
  output logic      out_tuser,
  output logic      out_tlast,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_wdata
);

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = IDX_W + 1;
  localparam int IN_W  = ((2*COORD_BITS + 2*IDX_W + 7) / 8) * 8;
  localparam int OUT_W = ((2*COORD_BITS + 3*IDX_W + 6 + 7) / 8) * 8;

  rls_pkg::cfg_t cfg_r;

  logic                  q_valid, q_pop;
  logic [2:0]            q_cmd;
  logic [COORD_BITS-1:0] q_x, q_y;
  logic [IDX_W-1:0]      q_ia, q_ib;

  // register writes; an index beyond the list is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fit_dist <= rls_pkg::FIT_DIST_RST;
      cfg_r.ext_dist <= rls_pkg::EXT_DIST_RST;
      cfg_r.max_hyp  <= rls_pkg::MAX_HYP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        rls_pkg::REG_FIT_DIST: cfg_r.fit_dist <= cfg_wdata;
        rls_pkg::REG_EXT_DIST: cfg_r.ext_dist <= cfg_wdata;
        rls_pkg::REG_MAX_HYP:  cfg_r.max_hyp  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // front: accept and classify requests into the queue
  rls_front #(.COORD_BITS(COORD_BITS), .IDX_W(IDX_W), .IN_W(IN_W)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_cmd     (q_cmd),
    .q_x       (q_x),
    .q_y       (q_y),
    .q_ia      (q_ia),
    .q_ib      (q_ib)
  );

  // back: point store, line setup, scan pipeline and result register
  rls_back #(
    .MAX_POINTS     (MAX_POINTS),
    .COORD_BITS     (COORD_BITS),
    .EXTRACT_WINDOW (EXTRACT_WINDOW),
    .IDX_W          (IDX_W),
    .CNT_W          (CNT_W),
    .OUT_W          (OUT_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_cmd      (q_cmd),
    .q_x        (q_x),
    .q_y        (q_y),
    .q_ia       (q_ia),
    .q_ib       (q_ib),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

// ===== sim/ransac_line_search_unit_tb.sv =====
`timescale 1ns / 1ps
module ransac_line_search_unit_tb;

  localparam int NPTS     = 4096;
  localparam int WIN      = 64;
  localparam int LIMIT    = 1500000;
  localparam int SETTLE   = 120;

  typedef struct {
    logic [1:0]  status;
    logic [12:0] hyp_cnt;
    logic [12:0] best_cnt;
    logic        improved;
    logic        done;
    logic        found;
    logic [10:0] px;
    logic [10:0] py;
    logic [11:0] pidx;
    logic        last;
  } line_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  wire         in_tready;
  logic [47:0] in_tdata = '0;
  logic [2:0]  in_tuser = rls_pkg::CMD_CLEAR;
  wire         out_tvalid;
  logic        out_tready = 1'b0;
  wire  [63:0] out_tdata;
  wire         out_tuser;
  wire         out_tlast;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = rls_pkg::REG_FIT_DIST;
  logic [7:0]  cfg_wdata = '0;

  ransac_line_search_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow of the block: point store, search state and registers
  bit [10:0]   store_x [NPTS];
  bit [10:0]   store_y [NPTS];
  bit          removed [NPTS];
  int unsigned total;
  int unsigned best_inliers;
  int unsigned hyps_used;
  bit          line_valid;
  bit [10:0]   lx1, ly1, lx2, ly2;
  bit [7:0]    fit_dist, ext_dist, max_hyp;

  line_result_t pending_results[$];
  int           fail_count = 0;
  bit           idle_on = 1'b1;
  int unsigned  cycles = 0;

  function automatic bit near_line(int x1, int y1, int x2, int y2, int px, int py, int d);
    longint dx, dy, cr;
    longint unsigned a, len2, rhs;
    dx = x2 - x1;
    dy = y2 - y1;
    cr = dx * (py - y1) - dy * (px - x1);
    a = (cr < 0) ? -cr : cr;
    len2 = dx * dx + dy * dy;
    rhs = longint'(d) * d * len2;
    if (a >= 64'h1_0000_0000) return 1'b0;
    return (a * a) < rhs;
  endfunction

  function automatic bit search_done();
    return best_inliers >= (total * 2) / 3 || hyps_used >= max_hyp;
  endfunction

  function automatic line_result_t make_result(logic [1:0] st, int hc, bit imp, bit found,
                                               int px, int py, int pidx, bit last);
    line_result_t r;
    r.status = st; r.hyp_cnt = 13'(hc); r.best_cnt = 13'(best_inliers); r.improved = imp;
    r.done = search_done(); r.found = found; r.px = 11'(px); r.py = 11'(py);
    r.pidx = 12'(pidx);
    r.last = last;
    return r;
  endfunction

  // Append one expectation at the tail of the queue
  function automatic void queue_expect(line_result_t r);
    pending_results.insert(pending_results.size(), r);
  endfunction

  // Work out every result one request causes and queue them in order
  task automatic predict_request(logic [2:0] cmd, int x, int y, int ia, int ib);
    int cnt;
    bit imp;
    int n_hits;
    int stop;
    case (cmd)
      rls_pkg::CMD_CLEAR: begin
        total = 0;
        best_inliers = 0; hyps_used = 0; line_valid = 0;
        {lx1, ly1, lx2, ly2} = '0;
        queue_expect(make_result(rls_pkg::ST_OK, 0, 0, 0, 0, 0, 0, 1));
      end
      rls_pkg::CMD_APPEND: begin
        if (total >= NPTS) begin
          queue_expect(make_result(rls_pkg::ST_FULL, 0, 0, 0, 0, 0, 0, 1));
        end else begin
          store_x[total] = 11'(x); store_y[total] = 11'(y); removed[total] = 0;
          total++;
          queue_expect(make_result(rls_pkg::ST_OK, 0, 0, 0, 0, 0, 0, 1));
        end
      end
      rls_pkg::CMD_NEW: begin
        best_inliers = 0; hyps_used = 0; line_valid = 0;
        {lx1, ly1, lx2, ly2} = '0;
        queue_expect(make_result(rls_pkg::ST_OK, 0, 0, 0, 0, 0, 0, 1));
      end
      rls_pkg::CMD_HYP: begin
        // short-circuit order matters: never look at an unwritten entry
        if (search_done() || ia >= total || ib >= total || removed[ia] || removed[ib] ||
            store_x[ia] == store_x[ib]) begin
          queue_expect(make_result(rls_pkg::ST_REJECT, 0, 0, 0, 0, 0, 0, 1));
        end else begin
          cnt = 0; imp = 0;
          for (int i = 0; i < total; i++)
            if (!removed[i] && near_line(store_x[ia], store_y[ia], store_x[ib], store_y[ib],
                                         store_x[i], store_y[i], fit_dist))
              cnt++;
          if (hyps_used < 255) hyps_used++;
          if (cnt > best_inliers) begin
            best_inliers = cnt; line_valid = 1; imp = 1;
            lx1 = store_x[ia]; ly1 = store_y[ia]; lx2 = store_x[ib]; ly2 = store_y[ib];
          end
          queue_expect(make_result(rls_pkg::ST_OK, cnt, imp, 0, 0, 0, 0, 1));
        end
      end
      rls_pkg::CMD_EXTRACT: begin
        if (ia >= total) begin
          queue_expect(make_result(rls_pkg::ST_REJECT, 0, 0, 0, 0, 0, 0, 1));
        end else if (!line_valid) begin
          queue_expect(make_result(rls_pkg::ST_OK, 0, 0, 0, 0, 0, 0, 1));
        end else begin
          n_hits = 0;
          stop = (ia + WIN > total) ? total : ia + WIN;
          for (int i = ia; i < stop; i++)
            if (!removed[i] && near_line(lx1, ly1, lx2, ly2, store_x[i], store_y[i],
                                         ext_dist)) begin
              removed[i] = 1;
              queue_expect(make_result(rls_pkg::ST_OK, 0, 0, 1, store_x[i], store_y[i], i,
                                       0));
              n_hits++;
            end
          if (n_hits == 0) begin
            queue_expect(make_result(rls_pkg::ST_OK, 0, 0, 0, 0, 0, 0, 1));
          end else begin
            pending_results[pending_results.size()-1].last = 1'b1;
          end
        end
      end
      default: queue_expect(make_result(rls_pkg::ST_OK, 0, 0, 0, 0, 0, 0, 1));
    endcase
  endtask

  // Send one request; keep valid high into the next request unless a gap is drawn
  task automatic send_request(logic [2:0] cmd, int x, int y, int ia, int ib);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {2'b00, ib[11:0], ia[11:0], y[10:0], x[10:0]};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_request(cmd, x, y, ia, ib);
  endtask

  // Drop valid and hold until every result is back and the block has settled
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Drive one register write for a cycle; the caller drops the enable
  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      rls_pkg::REG_FIT_DIST: fit_dist = val;
      rls_pkg::REG_EXT_DIST: ext_dist = val;
      rls_pkg::REG_MAX_HYP:  max_hyp = val;
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [7:0] fd, logic [7:0] ed, logic [7:0] mh);
    drain();
    write_reg(rls_pkg::REG_FIT_DIST, fd);
    write_reg(rls_pkg::REG_EXT_DIST, ed);
    write_reg(rls_pkg::REG_MAX_HYP, mh);
    cfg_we <= 1'b0;
  endtask

  function automatic int clamp_coord(int v);
    return (v < 0) ? 0 : (v > 2047) ? 2047 : v;
  endfunction

  // Append n points, most of them close to one random line
  task automatic append_line_set(int n);
    int base, slope, x;
    base  = $urandom_range(200, 1800);
    slope = int'($urandom_range(0, 32)) - 16;
    for (int i = 0; i < n; i++) begin
      x = $urandom_range(0, 2047);
      if ($urandom_range(0, 4) == 0)
        send_request(rls_pkg::CMD_APPEND, x, $urandom_range(0, 2047), 0, 0);
      else
        send_request(rls_pkg::CMD_APPEND, x,
                     clamp_coord(base + ((x - 1024) * slope) / 16 +
                                 int'($urandom_range(0, 6)) - 3),
                     0, 0);
    end
  endtask

  task automatic test_directed();
    logic [2:0] c;
    send_request(rls_pkg::CMD_CLEAR, 0, 0, 0, 0);
    // extract before any point and before any line
    send_request(rls_pkg::CMD_EXTRACT, 0, 0, 0, 0);
    send_request(rls_pkg::CMD_APPEND, 0, 0, 0, 0);
    send_request(rls_pkg::CMD_APPEND, 2047, 2047, 0, 0);
    send_request(rls_pkg::CMD_APPEND, 1024, 1024, 0, 0);
    send_request(rls_pkg::CMD_APPEND, 1024, 10, 0, 0);
    send_request(rls_pkg::CMD_APPEND, 500, 503, 0, 0);
    send_request(rls_pkg::CMD_EXTRACT, 0, 0, 0, 0);     // no valid line yet
    send_request(rls_pkg::CMD_HYP, 0, 0, 0, 4095);      // index out of range
    send_request(rls_pkg::CMD_HYP, 0, 0, 4095, 0);
    send_request(rls_pkg::CMD_HYP, 0, 0, 2, 3);         // equal x values
    send_request(rls_pkg::CMD_HYP, 0, 0, 0, 1);         // diagonal: counts the line points
    send_request(rls_pkg::CMD_EXTRACT, 0, 0, 4095, 0);  // window start out of range
    send_request(rls_pkg::CMD_EXTRACT, 0, 0, 0, 0);     // removes diagonal points
    send_request(rls_pkg::CMD_HYP, 0, 0, 0, 3);         // removed sample
    send_request(rls_pkg::CMD_NEW, 0, 0, 0, 0);
    send_request(rls_pkg::CMD_HYP, 0, 0, 3, 0);
    send_request(rls_pkg::CMD_HYP, 0, 0, 3, 1);
    // send each unknown command code; the loop ends when the code wraps back to clear
    for (c = rls_pkg::CMD_NONE; c != rls_pkg::CMD_CLEAR; c++)
      send_request(c, 2047, 2047, 4095, 4095);
  endtask

  task automatic test_search_done();
    set_regs(8'd0, 8'd0, 8'd1);
    send_request(rls_pkg::CMD_CLEAR, 0, 0, 0, 0);
    append_line_set(8);
    send_request(rls_pkg::CMD_HYP, 0, 0, 0, 1);         // zero distance: nothing counts
    send_request(rls_pkg::CMD_HYP, 0, 0, 1, 2);         // after done
    send_request(rls_pkg::CMD_EXTRACT, 0, 0, 0, 0);
    set_regs(8'd255, 8'd255, 8'd255);
    send_request(rls_pkg::CMD_NEW, 0, 0, 0, 0);
    send_request(rls_pkg::CMD_HYP, 0, 0, 0, 1);         // wide band reaches the target
    send_request(rls_pkg::CMD_HYP, 0, 0, 2, 3);
    send_request(rls_pkg::CMD_EXTRACT, 0, 0, 0, 0);
  endtask

  task automatic test_random_searches(int rounds);
    int n, a, b;
    for (int r = 0; r < rounds; r++) begin
      if (r % 3 == 0)
        set_regs(8'($urandom_range(0, 255) >> $urandom_range(0, 7)),
                 8'($urandom_range(0, 255) >> $urandom_range(0, 7)),
                 8'($urandom_range(1, 12)));
      if (r == rounds / 2) drain();                 // hold off until all results are in
      send_request(rls_pkg::CMD_CLEAR, 0, 0, 0, 0);
      n = $urandom_range(3, 30);
      append_line_set(n);
      send_request(rls_pkg::CMD_NEW, 0, 0, 0, 0);
      for (int h = 0; h < 6; h++) begin
        a = $urandom_range(0, n - 1);
        b = $urandom_range(0, n - 1);
        case ($urandom_range(0, 9))
          0: send_request(rls_pkg::CMD_HYP, 0, 0, $urandom_range(0, 4095), b);
          1: send_request(3'($urandom_range(5, 7)), $urandom_range(0, 2047),
                          $urandom_range(0, 2047), $urandom_range(0, 4095),
                          $urandom_range(0, 4095));
          2: send_request(rls_pkg::CMD_EXTRACT, 0, 0, $urandom_range(0, n + 2), 0);
          default: send_request(rls_pkg::CMD_HYP, $urandom_range(0, 2047),
                                $urandom_range(0, 2047), a, b);
        endcase
      end
      send_request(rls_pkg::CMD_EXTRACT, 0, 0, 0, $urandom_range(0, 4095));
      send_request(rls_pkg::CMD_HYP, 0, 0, 0, 1);
    end
  endtask

  // Result side: random stall bursts on out_tready
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(1, 17) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic check_field(string name, logic [15:0] expv, logic [15:0] actv);
    if (expv !== actv) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, expv, actv);
      fail_count++;
    end
  endtask

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    line_result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual tdata %h", $realtime,
                 out_tdata);
        fail_count++;
      end else begin
        e = pending_results.pop_front();
        check_field("status",      e.status,   out_tdata[1:0]);
        check_field("hyp_count",   e.hyp_cnt,  out_tdata[14:2]);
        check_field("best_count",  e.best_cnt, out_tdata[27:15]);
        check_field("improved",    e.improved, out_tdata[28]);
        check_field("search_done", e.done,     out_tdata[29]);
        check_field("point_x",     e.px,       out_tdata[40:30]);
        check_field("point_y",     e.py,       out_tdata[51:41]);
        check_field("point_index", e.pidx,     out_tdata[63:52]);
        check_field("point_found", e.found,    out_tuser);
        check_field("last",        e.last,     out_tlast);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    fit_dist = rls_pkg::FIT_DIST_RST;
    ext_dist = rls_pkg::EXT_DIST_RST;
    max_hyp  = rls_pkg::MAX_HYP_RST;
    total = 0; best_inliers = 0; hyps_used = 0; line_valid = 0;
    {lx1, ly1, lx2, ly2} = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_search_done();
    test_random_searches(3);
    drain();
    idle_on = 1'b0;
    test_random_searches(1);
    drain();
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/rls_pkg.sv
rtl/rls_ram.sv
rtl/rls_front.sv
rtl/rls_back.sv
rtl/ransac_line_search_unit.sv
sim/ransac_line_search_unit_tb.sv
